>>> hdl/irld_pkg.sv
// ----------------------------------------------------------------------------
// irld_pkg
// Shared types and constants of the indexed run-length pixel decoder.
// ----------------------------------------------------------------------------
package irld_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int COUNT_W       = 25;
  localparam int LIMIT_W       = 24;
  localparam int COLOUR_W      = 24;

  localparam logic [7:0] END_BYTE    = 8'd128;
  localparam logic [8:0] REPEAT_BASE = 9'd257;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_DATA    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_REPEAT  = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  // Decoded result waiting for its palette read
  typedef struct packed {
    logic       zero_colour;
    logic [7:0] run;
    logic       eoi;
  } res_t;

endpackage

>>> hdl/irld_palette_ram.sv
// ----------------------------------------------------------------------------
// irld_palette_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module irld_palette_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [irld_pkg::PAL_AW-1:0] wr_addr,
  input  irld_pkg::colour_t          wr_data,
  input  logic                       rd_en,
  input  logic [irld_pkg::PAL_AW-1:0] rd_addr,
  output irld_pkg::colour_t          rd_data
);

  irld_pkg::colour_t mem [irld_pkg::PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/irld_parser.sv
// ----------------------------------------------------------------------------
// irld_parser
// Packet parser: header decode, literal/repeat tracking, pixel count and
// limit check. Issues palette writes for palette requests and palette reads for results.
// ----------------------------------------------------------------------------
module irld_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      mode,
  input  logic [7:0]                      data_byte,
  input  logic [7:0]                      palette_slot,
  input  irld_pkg::colour_t               colour_in,
  input  logic                            limit_we,
  input  logic [irld_pkg::LIMIT_W-1:0]    limit_wdata,
  output logic                            res_valid,
  output irld_pkg::res_t                  res,
  output logic                            rd_en,
  output logic [irld_pkg::PAL_AW-1:0]     rd_addr,
  output logic                            wr_en,
  output logic [irld_pkg::PAL_AW-1:0]     wr_addr,
  output irld_pkg::colour_t               wr_data
);

  irld_pkg::phase_t                phase, phase_next;
  logic [7:0]                      literal_remaining, literal_remaining_next;
  logic [7:0]                      repeat_length, repeat_length_next;
  logic [irld_pkg::COUNT_W-1:0]    pixel_count, pixel_count_next;
  logic [irld_pkg::LIMIT_W-1:0]    pixel_limit;

  irld_pkg::mode_t                 mode_dec;
  logic [7:0]                      lit_dec;
  logic [7:0]                      add_n;
  logic [irld_pkg::COUNT_W:0]      count_sum;
  logic [irld_pkg::COUNT_W-1:0]    count_sat;
  logic                            over_limit;
  logic                            idx_in_range;
  logic                            slot_in_range;

  assign mode_dec      = irld_pkg::mode_t'(mode);
  assign idx_in_range  = {1'b0, data_byte} < 9'(irld_pkg::PALETTE_DEPTH);
  assign slot_in_range = {1'b0, palette_slot} < 9'(irld_pkg::PALETTE_DEPTH);

  assign lit_dec    = (literal_remaining != 8'd0) ? literal_remaining - 8'd1 : 8'd0;
  assign add_n      = (phase == irld_pkg::PH_REPEAT) ? repeat_length : 8'd1;
  assign count_sum  = {1'b0, pixel_count} + (irld_pkg::COUNT_W+1)'(add_n);
  assign count_sat  = count_sum[irld_pkg::COUNT_W] ? '1
                                                   : count_sum[irld_pkg::COUNT_W-1:0];
  assign over_limit = count_sat > irld_pkg::COUNT_W'(pixel_limit);

  assign wr_en   = accept && (mode_dec == irld_pkg::MODE_PALETTE) && slot_in_range;
  assign wr_addr = palette_slot[irld_pkg::PAL_AW-1:0];
  assign wr_data = colour_in;
  assign rd_addr = data_byte[irld_pkg::PAL_AW-1:0];
  assign rd_en   = res_valid;

  always_comb begin
    phase_next             = phase;
    literal_remaining_next = literal_remaining;
    repeat_length_next     = repeat_length;
    pixel_count_next       = pixel_count;
    res_valid              = 1'b0;
    res.zero_colour        = !idx_in_range;
    res.run                = 8'd1;
    res.eoi                = 1'b0;
    if (accept) begin
      unique case (mode_dec) inside
        irld_pkg::MODE_RESTART: begin
          phase_next             = irld_pkg::PH_HEADER;
          literal_remaining_next = 8'd0;
          repeat_length_next     = 8'd0;
          pixel_count_next       = '0;
        end
        irld_pkg::MODE_DATA: begin
          unique case (phase)
            irld_pkg::PH_HEADER: begin
              if (data_byte == irld_pkg::END_BYTE) begin
                phase_next      = irld_pkg::PH_DONE;
                res_valid       = 1'b1;
                res.zero_colour = 1'b1;
                res.run         = 8'd0;
                res.eoi         = 1'b1;
              end else if (data_byte < irld_pkg::END_BYTE) begin
                literal_remaining_next = data_byte + 8'd1;
                phase_next             = irld_pkg::PH_LITERAL;
              end else begin
                repeat_length_next = 8'(irld_pkg::REPEAT_BASE - {1'b0, data_byte});
                phase_next         = irld_pkg::PH_REPEAT;
              end
            end
            irld_pkg::PH_LITERAL: begin
              literal_remaining_next = lit_dec;
              pixel_count_next       = count_sat;
              res_valid              = 1'b1;
              // Limit is checked only on the last literal of the packet
              if (lit_dec == 8'd0) begin
                res.eoi    = over_limit;
                phase_next = over_limit ? irld_pkg::PH_DONE : irld_pkg::PH_HEADER;
              end
            end
            irld_pkg::PH_REPEAT: begin
              pixel_count_next = count_sat;
              res_valid        = 1'b1;
              res.run          = repeat_length;
              res.eoi          = over_limit;
              phase_next       = over_limit ? irld_pkg::PH_DONE : irld_pkg::PH_HEADER;
            end
            irld_pkg::PH_DONE: begin
              phase_next = irld_pkg::PH_DONE;
            end
            default: begin
              phase_next = irld_pkg::PH_HEADER;
            end
          endcase
        end
        irld_pkg::MODE_PALETTE, irld_pkg::MODE_UNUSED: begin
          phase_next = phase;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= irld_pkg::PH_HEADER;
      literal_remaining <= 8'd0;
      repeat_length     <= 8'd0;
      pixel_count       <= '0;
      pixel_limit       <= irld_pkg::LIMIT_RESET;
    end else begin
      phase             <= phase_next;
      literal_remaining <= literal_remaining_next;
      repeat_length     <= repeat_length_next;
      pixel_count       <= pixel_count_next;
      if (limit_we) begin
        pixel_limit <= limit_wdata;
      end
    end
  end

endmodule

>>> hdl/indexed_run_length_pixel_decoder.sv
// ----------------------------------------------------------------------------
// indexed_run_length_pixel_decoder
// Decodes a run-length byte stream of palette indices into colour runs.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request's result is registered in stage 1 alongside
//   its palette read data, then in the output register.
// Throughput: one request per cycle while stage 1 is not stalled; the palette
//   read port and the output register are each used once per result.
// Reset: clears parser state, counters, pixel limit (to all ones) and the
//   pipeline valids; palette contents are undefined until written.
module indexed_run_length_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte, palette_slot, red_in, green_in, blue_in
  input  logic [39:0] s_axis_tdata,
  // mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out, green_out, blue_out, run_length
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        pixel_limit_we,
  input  logic [23:0] pixel_limit_wdata
);

  logic                            accept;
  logic                            s1_adv;
  logic                            res_valid;
  irld_pkg::res_t                  res;
  logic                            rd_en;
  logic [irld_pkg::PAL_AW-1:0]     rd_addr;
  logic                            wr_en;
  logic [irld_pkg::PAL_AW-1:0]     wr_addr;
  irld_pkg::colour_t               wr_data;
  irld_pkg::colour_t               rd_data;
  irld_pkg::colour_t               colour_in;
  irld_pkg::colour_t               colour_sel;

  logic                            s1_valid;
  irld_pkg::res_t                  s1_res;

  assign s1_adv        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign colour_in = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};

  irld_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (s_axis_tuser),
    .data_byte    (s_axis_tdata[7:0]),
    .palette_slot (s_axis_tdata[15:8]),
    .colour_in    (colour_in),
    .limit_we     (pixel_limit_we),
    .limit_wdata  (pixel_limit_wdata),
    .res_valid    (res_valid),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  irld_palette_ram u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 1: result waits here alongside its palette read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= res_valid;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      s1_res <= res;
    end
  end

  assign colour_sel = s1_res.zero_colour ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      m_axis_tdata <= {s1_res.run, colour_sel[7:0], colour_sel[15:8], colour_sel[23:16]};
      m_axis_tlast <= s1_res.eoi;
    end
  end

  // Stalled stage 1 must block new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !s_axis_tready)
    else $error("request accepted while stage 1 is stalled");

  // A held stage 1 keeps its result
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_res))
    else $error("stage 1 result changed while stalled");

  // A zero run only comes from the end marker
  a_zero_run_is_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[31:24] == 8'd0) |-> m_axis_tlast)
    else $error("zero run length without end of image");

  // Palette reads only go with a result
  a_read_has_result: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> accept && res_valid)
    else $error("palette read without a result");

endmodule

>>> dv/irld_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irld_checker
// Watches both stream channels and the pixel limit port of the decoder. Keeps
// its own palette, parser state and pixel count to predict the colour run of
// every accepted request, then compares each delivered run in order.
// ----------------------------------------------------------------------------
module irld_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [39:0]                  s_tdata,
  input  logic [1:0]                   s_tuser,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [31:0]                  m_tdata,
  input  logic                         m_tlast,
  input  logic                         limit_we,
  input  logic [irld_pkg::LIMIT_W-1:0] limit_wdata,
  output int                           mismatches,
  output int                           outstanding,
  output int                           runs_checked,
  output int                           image_ends
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run;
    logic       eoi;
  } colour_run_t;

  localparam logic [irld_pkg::COUNT_W-1:0] COUNT_SAT = '1;

  irld_pkg::colour_t            palette_q [irld_pkg::PALETTE_DEPTH];
  logic [irld_pkg::LIMIT_W-1:0] limit_q = irld_pkg::LIMIT_RESET;
  irld_pkg::phase_t             phase_q = irld_pkg::PH_HEADER;
  logic [7:0]                   literals_left = '0;
  logic [7:0]                   repeat_len = '0;
  logic [irld_pkg::COUNT_W-1:0] pixel_cnt = '0;
  colour_run_t                  expected_runs [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    runs_checked = 0;
    image_ends   = 0;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 200)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic logic [irld_pkg::COUNT_W-1:0] sat_add(
      input logic [irld_pkg::COUNT_W-1:0] a, input logic [8:0] n);
    logic [irld_pkg::COUNT_W:0] sum;
    sum = {1'b0, a} + n;
    return (sum > {1'b0, COUNT_SAT}) ? COUNT_SAT : sum[irld_pkg::COUNT_W-1:0];
  endfunction

  // The limit is only checked when a packet completes
  task automatic finish_packet(input logic [8:0] n, output logic eoi);
    pixel_cnt = sat_add(pixel_cnt, n);
    eoi = pixel_cnt > {1'b0, limit_q};
    if (eoi)
      phase_q = irld_pkg::PH_DONE;
  endtask

  task automatic push_run(input logic [7:0] idx, input logic [7:0] run, input logic eoi);
    irld_pkg::colour_t c;
    colour_run_t       r;
    c = (idx < irld_pkg::PALETTE_DEPTH) ? palette_q[idx] : '0;
    r = '{red: c[23:16], green: c[15:8], blue: c[7:0], run: run, eoi: eoi};
    expected_runs.push_back(r);
  endtask

  task automatic decode_request(input irld_pkg::mode_t mode, input logic [7:0] data,
                                input logic [7:0] slot, input logic [7:0] red,
                                input logic [7:0] green, input logic [7:0] blue);
    logic eoi;
    eoi = 1'b0;
    case (mode)
      irld_pkg::MODE_PALETTE: begin
        if (slot < irld_pkg::PALETTE_DEPTH)
          palette_q[slot] = {red, green, blue};
      end
      irld_pkg::MODE_RESTART: begin
        phase_q       = irld_pkg::PH_HEADER;
        literals_left = '0;
        repeat_len    = '0;
        pixel_cnt     = '0;
      end
      irld_pkg::MODE_DATA: begin
        case (phase_q)
          irld_pkg::PH_HEADER: begin
            if (data == irld_pkg::END_BYTE) begin
              phase_q = irld_pkg::PH_DONE;
              expected_runs.push_back('{red: '0, green: '0, blue: '0, run: '0, eoi: 1'b1});
            end else if (data < irld_pkg::END_BYTE) begin
              literals_left = data + 8'd1;
              phase_q       = irld_pkg::PH_LITERAL;
            end else begin
              repeat_len = 8'(irld_pkg::REPEAT_BASE - data);
              phase_q    = irld_pkg::PH_REPEAT;
            end
          end
          irld_pkg::PH_LITERAL: begin
            if (literals_left != 0)
              literals_left--;
            if (literals_left == 0) begin
              phase_q = irld_pkg::PH_HEADER;
              finish_packet(9'd1, eoi);
            end else begin
              pixel_cnt = sat_add(pixel_cnt, 9'd1);
            end
            push_run(data, 8'd1, eoi);
          end
          irld_pkg::PH_REPEAT: begin
            phase_q = irld_pkg::PH_HEADER;
            finish_packet({1'b0, repeat_len}, eoi);
            push_run(data, repeat_len, eoi);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    colour_run_t got;
    colour_run_t want;
    if (rst) begin
      limit_q       = irld_pkg::LIMIT_RESET;
      phase_q       = irld_pkg::PH_HEADER;
      literals_left = '0;
      repeat_len    = '0;
      pixel_cnt     = '0;
      expected_runs.delete();
    end else begin
      // Check the delivered run before predicting the new request
      if (m_tvalid && m_tready) begin
        got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16],
                run: m_tdata[31:24], eoi: m_tlast};
        runs_checked++;
        if (got.eoi === 1'b1)
          image_ends++;
        if (expected_runs.size() == 0) begin
          report($sformatf("colour run %h with none expected", got));
        end else begin
          want = expected_runs.pop_front();
          if (got.red !== want.red)
            report($sformatf("red got %h want %h", got.red, want.red));
          if (got.green !== want.green)
            report($sformatf("green got %h want %h", got.green, want.green));
          if (got.blue !== want.blue)
            report($sformatf("blue got %h want %h", got.blue, want.blue));
          if (got.run !== want.run)
            report($sformatf("run length got %0d want %0d", got.run, want.run));
          if (got.eoi !== want.eoi)
            report($sformatf("end of image got %b want %b", got.eoi, want.eoi));
        end
      end
      if (limit_we)
        limit_q = limit_wdata;
      if (s_tvalid && s_tready)
        decode_request(irld_pkg::mode_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
                       s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]);
    end
    outstanding = expected_runs.size();
  end

endmodule

>>> dv/indexed_run_length_pixel_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_run_length_pixel_decoder_tb
// Drives palette writes, compressed byte streams and restarts into the
// decoder under several pixel limits, with random gaps and back-pressure on
// both sides. Results are checked by irld_checker; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module indexed_run_length_pixel_decoder_tb;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = irld_pkg::MODE_PALETTE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         pixel_limit_we = 1'b0;
  logic [23:0]  pixel_limit_wdata = '0;

  int           mismatches;
  int           outstanding;
  int           runs_checked;
  int           image_ends;

  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;
  bit           long_hold_req = 1'b0;
  int           sent_items = 0;
  int           image_pixels = 0;
  logic [23:0]  cur_limit = irld_pkg::LIMIT_RESET;

  indexed_run_length_pixel_decoder dut (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .pixel_limit_we    (pixel_limit_we),
    .pixel_limit_wdata (pixel_limit_wdata)
  );

  irld_checker chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_axis_tvalid),
    .s_tready     (s_axis_tready),
    .s_tdata      (s_axis_tdata),
    .s_tuser      (s_axis_tuser),
    .m_tvalid     (m_axis_tvalid),
    .m_tready     (m_axis_tready),
    .m_tdata      (m_axis_tdata),
    .m_tlast      (m_axis_tlast),
    .limit_we     (pixel_limit_we),
    .limit_wdata  (pixel_limit_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .runs_checked (runs_checked),
    .image_ends   (image_ends)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stall per result, plus one long hold on request
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_axis_tready = 1'b0;
        long_hold_req = 1'b0;
        repeat (300) @(negedge clk);
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Leaves tvalid high on return so that the next request can follow at once
  task automatic send_req(input irld_pkg::mode_t mode, input logic [7:0] data,
                          input logic [7:0] slot, input logic [23:0] rgb);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = mode;
    s_axis_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16], slot, data};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_req(irld_pkg::MODE_DATA, b, 8'($urandom), 24'($urandom));
  endtask

  task automatic write_colour(input logic [7:0] slot, input logic [23:0] rgb);
    send_req(irld_pkg::MODE_PALETTE, 8'($urandom), slot, rgb);
  endtask

  task automatic restart_image();
    send_req(irld_pkg::MODE_RESTART, 8'($urandom), 8'($urandom), 24'($urandom));
    image_pixels = 0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_limit(input logic [23:0] value);
    drain();
    pixel_limit_wdata = value;
    pixel_limit_we    = 1'b1;
    @(negedge clk);
    pixel_limit_we = 1'b0;
    cur_limit      = value;
  endtask

  task automatic send_packet();
    int         n;
    logic [7:0] hdr;
    if ($urandom_range(0, 1) == 1) begin
      n = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(1, 12);
      push_byte(8'(n - 1));
      repeat (n) push_byte(8'($urandom));
      image_pixels += n;
    end else begin
      hdr = 8'($urandom_range(129, 255));
      push_byte(hdr);
      push_byte(8'($urandom));
      image_pixels += 257 - hdr;
    end
  endtask

  task automatic run_images(input int budget);
    int first;
    int pick;
    first = sent_items;
    restart_image();
    while (sent_items - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        write_colour(8'($urandom), 24'($urandom));
      end else if (pick < 7) begin
        send_req(irld_pkg::MODE_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
      end else if (pick < 10) begin
        // end marker, a few dropped bytes, then a fresh image
        push_byte(irld_pkg::END_BYTE);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        restart_image();
      end else if (pick < 13) begin
        // broken packet: header or stray byte cut off by a restart
        push_byte(8'($urandom));
        restart_image();
      end else begin
        send_packet();
        if (image_pixels > cur_limit) begin
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
          restart_image();
        end
      end
    end
  endtask

  initial begin
    logic [23:0] limits [7];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extreme colours and slots, every mode, each packet kind
    write_colour(8'd0, 24'hFFFFFF);
    write_colour(8'd255, 24'h000000);
    write_colour(8'h5A, 24'hA5C35A);
    restart_image();
    send_req(irld_pkg::MODE_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF);
    push_byte(8'd0);
    push_byte(8'd0);
    push_byte(8'd2);
    push_byte(8'd255);
    push_byte(8'd0);
    push_byte(8'h5A);
    push_byte(8'd129);
    push_byte(8'd255);
    push_byte(8'd255);
    push_byte(8'd0);
    // palette write in the middle of a literal packet
    push_byte(8'd1);
    push_byte(8'd0);
    write_colour(8'd0, 24'h123456);
    push_byte(8'd0);
    push_byte(irld_pkg::END_BYTE);
    push_byte(8'd5);
    push_byte(8'd0);
    restart_image();

    // Fill the whole palette so any index is safe from here on
    for (int s = 0; s < irld_pkg::PALETTE_DEPTH; s++)
      write_colour(8'(s), 24'($urandom));

    limits = '{irld_pkg::LIMIT_RESET, 24'd0, 24'd1, 24'd128,
               24'($urandom_range(20, 600)), 24'($urandom), irld_pkg::LIMIT_RESET};
    for (int p = 0; p < 7; p++) begin
      set_limit(limits[p]);
      tx_quiet = (p == 2) || (p == 5);
      rx_quiet = (p == 3) || (p == 5);
      if (p == 0) begin
        // Hold the receiver off while a long literal packet streams in
        restart_image();
        long_hold_req = 1'b1;
        tx_quiet      = 1'b1;
        push_byte(8'd127);
        repeat (128) push_byte(8'($urandom));
        image_pixels += 128;
        tx_quiet = 1'b0;
      end
      run_images(205);
    end

    s_axis_tvalid = 1'b0;
    for (int i = 0; i < 20000 && outstanding != 0; i++)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (outstanding != 0)
      $display("%0d expected colour runs never arrived", outstanding);
    $display("Sent %0d requests across 7 pixel limit settings, including 0 and all ones.",
             sent_items);
    $display("Checked %0d colour runs, %0d of them marking end of image.",
             runs_checked, image_ends);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
